// ===== hw/rtl/cv2_pkg.sv =====
// ----------------------------------------------------------------------------
// cv2_pkg
// Shared types and codes for the streaming 2D correlation block.
// ----------------------------------------------------------------------------
package cv2_pkg;

	// request kinds on the input side
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic [3:0] REG_IMAGE_WIDTH   = 4'd0;
	localparam logic [3:0] REG_IMAGE_HEIGHT  = 4'd1;
	localparam logic [3:0] REG_KERNEL_WIDTH  = 4'd2;
	localparam logic [3:0] REG_KERNEL_HEIGHT = 4'd3;

	localparam logic [12:0] ROW_LIMIT = 13'd4096;

	typedef struct packed {
		logic [9:0]  out_col;
		logic [11:0] out_row;
		logic        last;
	} meta_t;

	// one classified word between front and back
	typedef struct packed {
		logic               is_pix;
		logic               ker_we;
		logic [5:0]         coef_index;
		logic signed [15:0] sample;
		logic               hit;
		meta_t              meta;
	} item_t;

	typedef struct packed {
		logic [31:0] sum;
		meta_t       meta;
	} res_t;

	// clamped kernel size in use
	typedef struct packed {
		logic [2:0] kw;
		logic [2:0] kh;
	} dims_t;

endpackage

// ===== hw/rtl/cv2_ram.sv =====
// ----------------------------------------------------------------------------
// cv2_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cv2_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/cv2_fifo.sv =====
// ----------------------------------------------------------------------------
// cv2_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module cv2_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       rd,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/cv2_front.sv =====
// ----------------------------------------------------------------------------
// cv2_front
// Configuration registers, raster counters and word classification.
// ----------------------------------------------------------------------------
module cv2_front #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_KERNEL_W = 7,
	parameter int MAX_KERNEL_H = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [3:0]                   wr_index,
	input  logic [12:0]                  wr_data,
	input  logic                         push,
	output logic                         full,
	input  logic                         req_type,
	input  logic [5:0]                   coef_index,
	input  logic signed [15:0]           sample,
	input  logic                         mq_full,
	input  logic                         busy,
	output logic                         mq_push,
	output cv2_pkg::item_t               mq_item,
	output logic [$clog2(MAX_WIDTH)-1:0] mq_addr,
	output cv2_pkg::dims_t               dims
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int KerDepth = MAX_KERNEL_W * MAX_KERNEL_H;

	logic [10:0]   width_q;
	logic [12:0]   height_q;
	logic [2:0]    kw_q;
	logic [2:0]    kh_q;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;

	logic [12:0]   w13, h13, col13, c13, r0, r13, nc, nr, ocol, orow;
	logic [2:0]    kw3, kh3;
	logic          wrap;
	logic [CW-1:0] col_n;
	logic [11:0]   row_n;
	logic          accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			kw_q     <= 3'd3;
			kh_q     <= 3'd3;
		end else if (wr_en) begin
			case (wr_index)
				cv2_pkg::REG_IMAGE_WIDTH:   width_q  <= wr_data[10:0];
				cv2_pkg::REG_IMAGE_HEIGHT:  height_q <= wr_data;
				cv2_pkg::REG_KERNEL_WIDTH:  kw_q     <= wr_data[2:0];
				cv2_pkg::REG_KERNEL_HEIGHT: kh_q     <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w13 = (width_q == '0) ? 13'd1 :
			(({2'b00, width_q} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'b00, width_q});
		h13 = (height_q == '0) ? 13'd1 :
			((height_q > cv2_pkg::ROW_LIMIT) ? cv2_pkg::ROW_LIMIT : height_q);
		kw3 = (kw_q == '0) ? 3'd1 :
			(({1'b0, kw_q} > 4'(MAX_KERNEL_W)) ? 3'(MAX_KERNEL_W) : kw_q);
		kh3 = (kh_q == '0) ? 3'd1 :
			(({1'b0, kh_q} > 4'(MAX_KERNEL_H)) ? 3'(MAX_KERNEL_H) : kh_q);

		// a column left beyond a narrowed width starts the next row
		col13 = 13'(col_q);
		wrap  = (col13 >= w13);
		c13   = wrap ? 13'd0 : col13;
		r0    = wrap ? 13'(row_q) + 13'd1 : 13'(row_q);
		r13   = (r0 >= h13) ? 13'd0 : r0;

		ocol = c13 - (13'(kw3) - 13'd1);
		orow = r13 - (13'(kh3) - 13'd1);

		nc = c13 + 13'd1;
		nr = r13 + 13'd1;
		if (nc >= w13) begin
			col_n = '0;
			row_n = (nr >= h13) ? 12'd0 : nr[11:0];
		end else begin
			col_n = nc[CW-1:0];
			row_n = r13[11:0];
		end
	end

	assign full    = mq_full || busy;
	assign accept  = push && !full;
	assign mq_push = accept;
	assign mq_addr = c13[CW-1:0];
	assign dims    = '{kw: kw3, kh: kh3};

	always_comb begin
		mq_item.is_pix        = (req_type == cv2_pkg::REQ_PIXEL);
		mq_item.ker_we        = (req_type == cv2_pkg::REQ_LOAD) && (int'(coef_index) < KerDepth);
		mq_item.coef_index    = coef_index;
		mq_item.sample        = sample;
		// only a pixel can complete a window
		mq_item.hit           = (req_type == cv2_pkg::REQ_PIXEL) &&
			(r13 >= 13'(kh3) - 13'd1) && (c13 >= 13'(kw3) - 13'd1);
		mq_item.meta.out_col  = ocol[9:0];
		mq_item.meta.out_row  = orow[11:0];
		mq_item.meta.last     = (r13 == h13 - 13'd1) && (c13 == w13 - 13'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && req_type == cv2_pkg::REQ_PIXEL) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

// ===== hw/rtl/cv2_back.sv =====
// ----------------------------------------------------------------------------
// cv2_back
// Line buffers, window, multiplier array and registered adder tree.
// ----------------------------------------------------------------------------
module cv2_back #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_KERNEL_W = 7,
	parameter int MAX_KERNEL_H = 7,
	parameter int OUT_DEPTH    = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  cv2_pkg::item_t                   q_item,
	input  logic [$clog2(MAX_WIDTH)-1:0]     q_addr,
	output logic                             q_pop,
	input  cv2_pkg::dims_t                   dims,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
	output logic                             busy,
	output logic                             res_vld,
	output cv2_pkg::res_t                    res
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int KW  = MAX_KERNEL_W;
	localparam int KH  = MAX_KERNEL_H;
	localparam int KD  = KW * KH;
	localparam int LV  = $clog2(KD);
	localparam int NP  = 2 ** LV;
	localparam int NLN = (KH > 1) ? KH - 1 : 1;
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	// line buffer clear after reset
	logic          clr_q;
	logic [CW-1:0] clr_addr_q;

	logic           issue;
	logic [OCW:0]   credit_sum;
	logic [OCW-1:0] inflight_q;

	logic           s1_vld_q;
	cv2_pkg::item_t s1_item_q;
	logic [CW-1:0]  s1_addr_q;
	logic           fwd_s1;
	logic [15:0]    fwd_data_s1 [NLN];
	logic           fwd_d;

	logic [15:0]        rd_data [NLN];
	logic signed [15:0] col_vec [KH];
	logic               ram_we;
	logic [CW-1:0]      ram_waddr;

	logic signed [15:0] win_q [KH][KW];
	logic signed [15:0] ker_q [KD];
	logic signed [15:0] map_d [KH][KW];
	logic signed [15:0] map_q [KH][KW];

	logic               s2_vld_q;
	cv2_pkg::meta_t     s2_meta_q;
	logic signed [31:0] prod_d [KD];
	logic [31:0]        tree_q [LV+1][NP];
	logic               t_vld_q [LV+1];
	cv2_pkg::meta_t     t_meta_q [LV+1];

	assign busy       = clr_q;
	assign credit_sum = (OCW+1)'(out_count) + (OCW+1)'(inflight_q);
	assign issue      = !q_empty && !clr_q && (credit_sum < (OCW+1)'(OUT_DEPTH));
	assign q_pop      = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({issue && q_item.hit, res_vld})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: ;
			endcase
		end
	end

	// column vector: entry 0 is the new pixel, entry m is the row m back
	always_comb begin
		col_vec[0] = s1_item_q.sample;
		for (int m = 1; m < KH; m++) begin
			col_vec[m] = fwd_s1 ? fwd_data_s1[m-1] : rd_data[m-1];
		end
	end

	// the word ahead writes the same column in the cycle this one reads it
	assign fwd_d     = s1_vld_q && s1_item_q.is_pix && (s1_addr_q == q_addr);
	assign ram_we    = clr_q || (s1_vld_q && s1_item_q.is_pix);
	assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;

	for (genvar g = 0; g < KH - 1; g++) begin : g_line
		cv2_ram #(
			.WIDTH(16),
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk  (clk),
			.we   (ram_we),
			.waddr(ram_waddr),
			.wdata(clr_q ? 16'd0 : col_vec[g]),
			.raddr(q_addr),
			.rdata(rd_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= issue;
			s2_vld_q <= s1_vld_q && s1_item_q.is_pix && s1_item_q.hit;
		end
	end

	always_ff @(posedge clk) begin
		s1_item_q <= q_item;
		s1_addr_q <= q_addr;
		fwd_s1    <= fwd_d;
		for (int m = 0; m < NLN; m++) begin
			fwd_data_s1[m] <= col_vec[m];
		end
		s2_meta_q <= s1_item_q.meta;
	end

	// window shift: column 0 is the newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < KH; m++) begin
				for (int j = 0; j < KW; j++) begin
					win_q[m][j] <= '0;
				end
			end
		end else if (s1_vld_q && s1_item_q.is_pix) begin
			for (int m = 0; m < KH; m++) begin
				for (int j = KW - 1; j > 0; j--) begin
					win_q[m][j] <= win_q[m][j-1];
				end
				win_q[m][0] <= col_vec[m];
			end
		end
	end

	// coefficient load, in order with the pixels around it
	always_ff @(posedge clk) begin
		for (int i = 0; i < KD; i++) begin
			if (s1_vld_q && s1_item_q.ker_we && int'(s1_item_q.coef_index) == i) begin
				ker_q[i] <= s1_item_q.sample;
			end
		end
	end

	// align the kernel to the window: slot (m, j) takes (kh-1-m, kw-1-j)
	always_comb begin
		for (int m = 0; m < KH; m++) begin
			for (int j = 0; j < KW; j++) begin
				map_d[m][j] = '0;
				for (int l = 0; l < KH; l++) begin
					for (int k = 0; k < KW; k++) begin
						if (l + m + 1 == int'(dims.kh) && k + j + 1 == int'(dims.kw)) begin
							map_d[m][j] = ker_q[l*KW+k];
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int m = 0; m < KH; m++) begin
			for (int j = 0; j < KW; j++) begin
				prod_d[m*KW+j] = win_q[m][j] * map_q[m][j];
			end
		end
	end

	always_ff @(posedge clk) begin
		map_q <= map_d;
		for (int i = 0; i < KD; i++) begin
			tree_q[0][i] <= prod_d[i];
		end
		for (int i = KD; i < NP; i++) begin
			tree_q[0][i] <= 32'd0;
		end
		for (int l = 1; l <= LV; l++) begin
			for (int i = 0; i < (NP >> l); i++) begin
				tree_q[l][i] <= tree_q[l-1][2*i] + tree_q[l-1][2*i+1];
			end
		end
		t_meta_q[0] <= s2_meta_q;
		for (int l = 1; l <= LV; l++) begin
			t_meta_q[l] <= t_meta_q[l-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= LV; l++) begin
				t_vld_q[l] <= 1'b0;
			end
		end else begin
			t_vld_q[0] <= s2_vld_q;
			for (int l = 1; l <= LV; l++) begin
				t_vld_q[l] <= t_vld_q[l-1];
			end
		end
	end

	assign res_vld  = t_vld_q[LV];
	assign res.sum  = tree_q[LV][0];
	assign res.meta = t_meta_q[LV];

	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !clr_q)
		else $error("word issued during line buffer clear");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= OCW'(OUT_DEPTH))
		else $error("in-flight count beyond output queue depth");

	a_room_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> (out_count < OCW'(OUT_DEPTH)))
		else $error("result arrives with the output queue full");

endmodule

// ===== hw/rtl/conv2d_valid_s16.sv =====
// ----------------------------------------------------------------------------
// conv2d_valid_s16
// Streaming valid-mode 2D correlation of signed 16-bit pixels.
// ----------------------------------------------------------------------------
// One word (coefficient load or pixel) is taken per clock while full is low.
// A pixel passes the middle queue, stage s1, the window and product registers
// and the adder tree levels before its sum enters the output queue; the line
// buffers take one read and one write per clock, which sets the rate of one
// pixel a cycle. After reset the line buffers are swept to zero, during which
// full stays high; register writes are taken throughout. Coefficient loads
// travel in order with pixels, so a load affects only pixels pushed after it.
module conv2d_valid_s16 #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_KERNEL_W = 7,
	parameter int MAX_KERNEL_H = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [3:0]         wr_index,
	input  logic [12:0]        wr_data,
	input  logic               push,
	output logic               full,
	input  logic               req_type,
	input  logic [5:0]         coef_index,
	input  logic signed [15:0] sample,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] sum_value,
	output logic [9:0]         out_col,
	output logic [11:0]        out_row,
	output logic               frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MidDepth = 4;
	localparam int OutDepth = 16;
	localparam int ItemW = $bits(cv2_pkg::item_t);
	localparam int ResW = $bits(cv2_pkg::res_t);

	logic                             mq_push, mq_full, mq_empty, mq_pop;
	cv2_pkg::item_t                   mq_item, q_item;
	logic [CW-1:0]                    mq_addr, q_addr;
	logic [$clog2(MidDepth+1)-1:0]    mq_count;
	cv2_pkg::dims_t                   dims;
	logic                             busy;
	logic                             res_vld;
	cv2_pkg::res_t                    res, head;
	logic [$clog2(OutDepth+1)-1:0]    out_count;
	logic                             out_full;

	cv2_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_KERNEL_W(MAX_KERNEL_W),
		.MAX_KERNEL_H(MAX_KERNEL_H)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.coef_index(coef_index),
		.sample    (sample),
		.mq_full   (mq_full),
		.busy      (busy),
		.mq_push   (mq_push),
		.mq_item   (mq_item),
		.mq_addr   (mq_addr),
		.dims      (dims)
	);

	cv2_fifo #(
		.WIDTH(ItemW + CW),
		.DEPTH(MidDepth)
	) u_midq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (mq_push),
		.wdata ({mq_item, mq_addr}),
		.rd    (mq_pop),
		.rdata ({q_item, q_addr}),
		.full  (mq_full),
		.empty (mq_empty),
		.count (mq_count)
	);

	cv2_back #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_KERNEL_W(MAX_KERNEL_W),
		.MAX_KERNEL_H(MAX_KERNEL_H),
		.OUT_DEPTH   (OutDepth)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mq_empty || (mq_count == '0)),
		.q_item   (q_item),
		.q_addr   (q_addr),
		.q_pop    (mq_pop),
		.dims     (dims),
		.out_count(out_count),
		.busy     (busy),
		.res_vld  (res_vld),
		.res      (res)
	);

	cv2_fifo #(
		.WIDTH(ResW),
		.DEPTH(OutDepth)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_vld),
		.wdata (res),
		.rd    (pop),
		.rdata (head),
		.full  (out_full),
		.empty (empty),
		.count (out_count)
	);

	assign sum_value  = head.sum;
	assign out_col    = head.meta.out_col;
	assign out_row    = head.meta.out_row;
	assign frame_last = head.meta.last;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> !out_full)
		else $error("result word dropped at output queue");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Regression for conv2d_valid_s16: a queue-fed driver pushes coefficient
// loads and pixels, a golden window model predicts each sum, and a monitor
// pops results under random stalls and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int LINE_W   = 1024;
	localparam int KER_W    = 7;
	localparam int KER_H    = 7;
	localparam int DOG_MAX  = 20000;

	typedef struct {
		logic               kind;
		logic [5:0]         idx;
		logic signed [15:0] val;
	} word_t;

	typedef struct {
		logic signed [31:0] sum;
		logic [9:0]         col;
		logic [11:0]        row;
		logic               last;
	} sum_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [3:0]         wr_index;
	logic [12:0]        wr_data;
	logic               push;
	logic               full;
	logic               req_type;
	logic [5:0]         coef_index;
	logic signed [15:0] sample;
	logic               empty;
	logic               pop;
	logic signed [31:0] sum_value;
	logic [9:0]         out_col;
	logic [11:0]        out_row;
	logic               frame_last;

	word_t word_q[$];
	sum_t  sums_q[$];
	int    errors;
	int    idle_mode;
	int    hold_cycles;
	int    dog;
	int    pix_total;

	// golden model state
	logic signed [15:0] coef_m[KER_W*KER_H];
	logic signed [15:0] lines_m[KER_H][LINE_W];
	logic signed [15:0] win_m[KER_H][KER_W];
	int cfg_w, cfg_h, cfg_kw, cfg_kh;
	int col_m, row_m;

	conv2d_valid_s16 dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .push(push), .full(full), .req_type(req_type),
		.coef_index(coef_index), .sample(sample), .empty(empty), .pop(pop),
		.sum_value(sum_value), .out_col(out_col), .out_row(out_row),
		.frame_last(frame_last)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic bit conv_step(input word_t wd, output sum_t res);
		int w, h, kw, kh, c, r;
		logic signed [15:0] column[KER_H];
		logic [31:0] acc;
		int p;
		res = '{default: '0};
		if (wd.kind == cv2_pkg::REQ_LOAD) begin
			if (wd.idx < KER_W*KER_H) coef_m[wd.idx] = wd.val;
			return 1'b0;
		end
		w  = clampi(cfg_w, 1, LINE_W);
		h  = clampi(cfg_h, 1, 4096);
		kw = clampi(cfg_kw, 1, KER_W);
		kh = clampi(cfg_kh, 1, KER_H);
		if (col_m >= w) begin
			col_m = 0;
			row_m++;
		end
		if (row_m >= h) row_m = 0;
		c = col_m;
		r = row_m;
		column[0] = wd.val;
		for (int m = 1; m < KER_H; m++) column[m] = lines_m[m-1][c];
		for (int m = KER_H-1; m > 0; m--) lines_m[m][c] = lines_m[m-1][c];
		lines_m[0][c] = wd.val;
		for (int m = 0; m < KER_H; m++) begin
			for (int k = KER_W-1; k > 0; k--) win_m[m][k] = win_m[m][k-1];
			win_m[m][0] = column[m];
		end
		col_m = c + 1;
		if (col_m >= w) begin
			col_m = 0;
			row_m = r + 1;
			if (row_m >= h) row_m = 0;
		end
		if (r + 1 >= kh && c + 1 >= kw) begin
			acc = '0;
			for (int l = 0; l < kh; l++)
				for (int k = 0; k < kw; k++) begin
					p = int'(coef_m[l*KER_W+k]) * int'(win_m[kh-1-l][kw-1-k]);
					acc += p;
				end
			res.sum  = acc;
			res.col  = 10'(c + 1 - kw);
			res.row  = 12'(r + 1 - kh);
			res.last = (r == h-1 && c == w-1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit chance(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	// driver: present the head of the pending queue, advance on acceptance
	always @(posedge clk or negedge arst_n) begin
		sum_t res;
		word_t wd;
		if (!arst_n) begin
			push       <= 1'b0;
			req_type   <= 1'b0;
			coef_index <= '0;
			sample     <= '0;
		end else begin
			if (push && !full) begin
				wd = '{req_type, coef_index, sample};
				if (conv_step(wd, res)) sums_q.push_back(res);
				void'(word_q.pop_front());
			end
			if (!push || !full) begin
				if (word_q.size() > 0 &&
				    !chance(idle_mode == 1 ? 48 : (idle_mode == 3 ? 30 : 0))) begin
					push       <= 1'b1;
					req_type   <= word_q[0].kind;
					coef_index <= word_q[0].idx;
					sample     <= word_q[0].val;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: pop results and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		sum_t ex;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (sums_q.size() == 0) begin
					$error("unexpected word: sum %0d col %0d row %0d",
						sum_value, out_col, out_row);
					errors++;
				end else begin
					ex = sums_q.pop_front();
					if (sum_value !== ex.sum) begin
						$error("sum_value exp %0d got %0d", ex.sum, sum_value);
						errors++;
					end
					if (out_col !== ex.col) begin
						$error("out_col exp %0d got %0d", ex.col, out_col);
						errors++;
					end
					if (out_row !== ex.row) begin
						$error("out_row exp %0d got %0d", ex.row, out_row);
						errors++;
					end
					if (frame_last !== ex.last) begin
						$error("frame_last exp %0d got %0d", ex.last, frame_last);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				pop <= 1'b0;
			end else begin
				pop <= !chance(idle_mode == 2 ? 48 : (idle_mode == 3 ? 30 : 0));
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || wr_en) begin
			dog <= 0;
		end else if (dog >= DOG_MAX) begin
			$display("conv2d_valid_s16 regression: fail");
			$finish;
		end else begin
			dog <= dog + 1;
		end
	end

	task automatic write_reg(input logic [3:0] idx, input int data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= 13'(data);
		case (idx)
			cv2_pkg::REG_IMAGE_WIDTH:   cfg_w  = data & 'h7ff;
			cv2_pkg::REG_IMAGE_HEIGHT:  cfg_h  = data & 'h1fff;
			cv2_pkg::REG_KERNEL_WIDTH:  cfg_kw = data & 'h7;
			cv2_pkg::REG_KERNEL_HEIGHT: cfg_kh = data & 'h7;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_size(int w, int h, int kw, int kh);
		write_reg(cv2_pkg::REG_IMAGE_WIDTH, w);
		write_reg(cv2_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(cv2_pkg::REG_KERNEL_WIDTH, kw);
		write_reg(cv2_pkg::REG_KERNEL_HEIGHT, kh);
	endtask

	// hold until every word is through and the pipe has run dry
	task automatic settle();
		while (word_q.size() > 0 || push || sums_q.size() > 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic add_pix(logic signed [15:0] v);
		word_q.push_back('{cv2_pkg::REQ_PIXEL, 6'd0, v});
		pix_total++;
	endtask

	task automatic add_random(int n, int load_pct);
		for (int i = 0; i < n; i++) begin
			if (chance(load_pct))
				word_q.push_back('{cv2_pkg::REQ_LOAD, 6'($urandom_range(63, 0)),
					16'($urandom)});
			else
				add_pix(16'($urandom));
		end
	endtask

	initial begin
		int n;
		errors = 0; idle_mode = 0; hold_cycles = 0; dog = 0; pix_total = 0;
		cfg_w = 1024; cfg_h = 1024; cfg_kw = 3; cfg_kh = 3;
		col_m = 0; row_m = 0;
		foreach (coef_m[i]) coef_m[i] = '0;
		foreach (lines_m[i, j]) lines_m[i][j] = '0;
		foreach (win_m[i, j]) win_m[i][j] = '0;
		arst_n = 1'b0; wr_en = 1'b0; wr_index = '0; wr_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full kernel load with extremes, dropped loads, edge pixels
		set_size(5, 4, 3, 2);
		for (int i = 0; i < KER_W*KER_H; i++)
			word_q.push_back('{cv2_pkg::REQ_LOAD, 6'(i),
				(i == 0) ? 16'sh8000 : (i == 1) ? 16'sh7fff : 16'($urandom)});
		word_q.push_back('{cv2_pkg::REQ_LOAD, 6'd49, 16'sh1234});
		word_q.push_back('{cv2_pkg::REQ_LOAD, 6'd63, 16'sh7fff});
		for (int i = 0; i < 20; i++)
			add_pix(i[0] ? 16'sh8000 : 16'sh7fff);
		settle();

		// extremes of the registers
		set_size(0, 0, 0, 0);
		add_random(20, 10);
		settle();
		set_size(2047, 8191, 7, 7);
		add_random(60, 10);
		settle();
		set_size(1024, 1, 7, 1);
		add_random(1024, 2);
		settle();
		set_size(1, 4096, 1, 7);
		add_random(50, 10);
		settle();
		// kernel larger than the image: nothing comes out
		set_size(3, 2, 5, 4);
		add_random(20, 0);
		settle();

		// long receiver hold-off while the sender keeps offering
		set_size(6, 5, 2, 2);
		hold_cycles = 400;
		add_random(120, 5);
		settle();

		for (int ph = 0; ph < 4 || pix_total < 1300; ph++) begin
			idle_mode = ph % 4;
			set_size($urandom_range(12, 1), $urandom_range(8, 1),
				$urandom_range(7, 0), $urandom_range(7, 0));
			n = $urandom_range(60, 10);
			add_random(n, 10);
			settle();
		end

		idle_mode = 0;
		settle();
		if (errors == 0) begin
			$display("conv2d_valid_s16 regression: pass");
		end else begin
			$display("conv2d_valid_s16 regression: fail");
		end
		$finish;
	end

endmodule
